FILE: src/m68kbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m68kbr_pkg
// Opcode patterns, condition codes and the condition test for the
// 68000 branch resolver.
// ----------------------------------------------------------------------------
package m68kbr_pkg;

  // Opcode classes
  localparam logic [3:0]  BranchFamily = 4'h6;
  localparam logic [12:0] DbfPattern   = 13'h0A39;   // 0x51C8 >> 3
  localparam logic [7:0]  DispWord     = 8'h00;
  localparam logic [7:0]  DispLong     = 8'hFF;

  // Instruction lengths in bytes
  localparam logic [31:0] LenShort = 32'd2;
  localparam logic [31:0] LenWord  = 32'd4;
  localparam logic [31:0] LenLong  = 32'd6;
  localparam logic [31:0] PushSize = 32'd4;

  localparam logic [15:0] CountWrap = 16'hFFFF;

  // Condition field of the branch family
  localparam logic [3:0] CondT  = 4'd0;
  localparam logic [3:0] CondSr = 4'd1;   // BSR
  localparam logic [3:0] CondHi = 4'd2;
  localparam logic [3:0] CondLs = 4'd3;
  localparam logic [3:0] CondCc = 4'd4;
  localparam logic [3:0] CondCs = 4'd5;
  localparam logic [3:0] CondNe = 4'd6;
  localparam logic [3:0] CondEq = 4'd7;
  localparam logic [3:0] CondVc = 4'd8;
  localparam logic [3:0] CondVs = 4'd9;
  localparam logic [3:0] CondPl = 4'd10;
  localparam logic [3:0] CondMi = 4'd11;
  localparam logic [3:0] CondGe = 4'd12;
  localparam logic [3:0] CondLt = 4'd13;
  localparam logic [3:0] CondGt = 4'd14;
  localparam logic [3:0] CondLe = 4'd15;

  typedef logic [4:0] flags_t;

  // Evaluate a condition against C V Z N (X is ignored)
  function automatic logic cond_true(input logic [3:0] cc, input flags_t f);
    logic c;
    logic v;
    logic z;
    logic n;
    logic r;
    c = f[0];
    v = f[1];
    z = f[2];
    n = f[3];
    case (cc)
      CondHi:  r = !c && !z;
      CondLs:  r = c || z;
      CondCc:  r = !c;
      CondCs:  r = c;
      CondNe:  r = !z;
      CondEq:  r = z;
      CondVc:  r = !v;
      CondVs:  r = v;
      CondPl:  r = !n;
      CondMi:  r = n;
      CondGe:  r = (n == v);
      CondLt:  r = (n != v);
      CondGt:  r = !z && (n == v);
      CondLe:  r = z || (n != v);
      default: r = 1'b1;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: src/m68k_branch_resolve.sv
`default_nettype none
// ----------------------------------------------------------------------------
// m68k_branch_resolve
// Resolves one 68000 BRA/BSR/Bcc/DBF instruction into next PC, stack push
// and counter write-back.
// ----------------------------------------------------------------------------
// The result passes through the input register, then the result register.
// Throughput: one transaction per cycle; busy is never raised since the path
// is a single registered pass.
// The result is shown for one cycle under done_o; the receiver cannot stall.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload registers
// are not reset.
module m68k_branch_resolve (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [15:0]           opcode_i,
  input  wire logic [15:0]           ext_first_i,
  input  wire logic [15:0]           ext_second_i,
  input  wire logic [31:0]           opcode_address_i,
  input  wire m68kbr_pkg::flags_t    flags_i,
  input  wire logic [15:0]           count_low_i,
  input  wire logic [31:0]           stack_pointer_i,
  output logic                       done_o,
  output logic [31:0]                next_pc_o,
  output logic                       taken_o,
  output logic [15:0]                count_new_o,
  output logic                       count_write_o,
  output logic                       push_valid_o,
  output logic [31:0]                push_address_o,
  output logic [31:0]                return_address_o,
  output logic [31:0]                stack_pointer_new_o,
  output logic                       unhandled_o
);
  import m68kbr_pkg::*;

  // --------------------------------------------------------------------------
  // Handshake: every cycle is open for a new transaction.
  // --------------------------------------------------------------------------
  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // --------------------------------------------------------------------------
  // Input register stage
  // --------------------------------------------------------------------------
  logic        in_vld_q;
  logic [15:0] op_q;
  logic [15:0] ext1_q;
  logic [15:0] ext2_q;
  logic [31:0] addr_q;
  flags_t      flags_q;
  logic [15:0] cnt_q;
  logic [31:0] sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept;
    end
  end

  // Capture payload only on an accepted transaction
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= opcode_i;
      ext1_q  <= ext_first_i;
      ext2_q  <= ext_second_i;
      addr_q  <= opcode_address_i;
      flags_q <= flags_i;
      cnt_q   <= count_low_i;
      sp_q    <= stack_pointer_i;
    end
  end

  // --------------------------------------------------------------------------
  // Decode and resolve
  // --------------------------------------------------------------------------
  logic        is_branch;
  logic        is_dbf;
  logic [3:0]  cc;
  logic [7:0]  low_byte;
  logic [31:0] disp;
  logic [31:0] len;
  logic [31:0] target;
  logic [31:0] fall_thru;
  logic [31:0] sp_dec;
  logic [15:0] cnt_dec;

  assign is_branch = (op_q[15:12] == BranchFamily);
  assign is_dbf    = (op_q[15:3] == DbfPattern);
  assign cc        = op_q[11:8];
  assign low_byte  = op_q[7:0];

  // Displacement and instruction length. DBF always uses the word form,
  // and its low byte (0xC8..0xCF) would pick the short form, so force it.
  always_comb begin
    if (is_dbf || low_byte == DispWord) begin
      disp = {{16{ext1_q[15]}}, ext1_q};
      len  = LenWord;
    end else if (low_byte == DispLong) begin
      disp = {ext1_q, ext2_q};
      len  = LenLong;
    end else begin
      disp = {{24{low_byte[7]}}, low_byte};
      len  = LenShort;
    end
  end

  assign target    = addr_q + LenShort + disp;
  assign fall_thru = addr_q + len;
  assign sp_dec    = sp_q - PushSize;
  assign cnt_dec   = cnt_q - 16'd1;

  logic [31:0] next_pc_d;
  logic        taken_d;
  logic [15:0] count_new_d;
  logic        count_write_d;
  logic        push_valid_d;
  logic [31:0] push_address_d;
  logic [31:0] return_address_d;
  logic [31:0] stack_pointer_new_d;
  logic        unhandled_d;

  always_comb begin
    // Defaults describe an unhandled opcode; unhandled_d itself is raised below
    next_pc_d           = addr_q;
    taken_d             = 1'b0;
    count_new_d         = '0;
    count_write_d       = 1'b0;
    push_valid_d        = 1'b0;
    push_address_d      = '0;
    return_address_d    = '0;
    stack_pointer_new_d = sp_q;
    unhandled_d         = 1'b0;

    if (is_branch) begin
      if (cc == CondSr) begin
        // BSR: predecrement A7 and push the return address
        push_valid_d        = 1'b1;
        push_address_d      = sp_dec;
        stack_pointer_new_d = sp_dec;
        return_address_d    = fall_thru;
        next_pc_d           = target;
        taken_d             = 1'b1;
      end else if (cond_true(cc, flags_q)) begin
        next_pc_d = target;
        taken_d   = 1'b1;
      end else begin
        next_pc_d = fall_thru;
      end
    end else if (is_dbf) begin
      // DBF: always write back; fall through on wrap to all ones
      count_new_d   = cnt_dec;
      count_write_d = 1'b1;
      if (cnt_dec == CountWrap) begin
        next_pc_d = fall_thru;
      end else begin
        next_pc_d = target;
        taken_d   = 1'b1;
      end
    end else begin
      unhandled_d = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result register stage
  // --------------------------------------------------------------------------
  logic        done_q;
  logic [31:0] next_pc_q;
  logic        taken_q;
  logic [15:0] count_new_q;
  logic        count_write_q;
  logic        push_valid_q;
  logic [31:0] push_address_q;
  logic [31:0] return_address_q;
  logic [31:0] stack_pointer_new_q;
  logic        unhandled_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  // Advance the result only when a transaction moves out of the input stage
  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      next_pc_q           <= next_pc_d;
      taken_q             <= taken_d;
      count_new_q         <= count_new_d;
      count_write_q       <= count_write_d;
      push_valid_q        <= push_valid_d;
      push_address_q      <= push_address_d;
      return_address_q    <= return_address_d;
      stack_pointer_new_q <= stack_pointer_new_d;
      unhandled_q         <= unhandled_d;
    end
  end

  assign done_o              = done_q;
  assign next_pc_o           = next_pc_q;
  assign taken_o             = taken_q;
  assign count_new_o         = count_new_q;
  assign count_write_o       = count_write_q;
  assign push_valid_o        = push_valid_q;
  assign push_address_o      = push_address_q;
  assign return_address_o    = return_address_q;
  assign stack_pointer_new_o = stack_pointer_new_q;
  assign unhandled_o         = unhandled_q;

endmodule
`default_nettype wire
